/* rtl/atdf_pkg.sv */
// Package for the AT response deframer: payload structs, the internal result
// bundle and the fixed byte positions of the frame header.
// No dependencies.
package atdf_pkg;

   localparam int unsigned IdxWidth = 17;

   // Header byte positions within a frame
   localparam logic [IdxWidth-1:0] IdxLenHi    = 17'd1;
   localparam logic [IdxWidth-1:0] IdxLenLo    = 17'd2;
   localparam logic [IdxWidth-1:0] IdxSumStart = 17'd3;
   localparam logic [IdxWidth-1:0] IdxIdent    = 17'd4;
   localparam logic [IdxWidth-1:0] IdxCmdHi    = 17'd5;
   localparam logic [IdxWidth-1:0] IdxCmdLo    = 17'd6;
   localparam logic [IdxWidth-1:0] IdxStatus   = 17'd7;
   localparam logic [IdxWidth-1:0] IdxParam    = 17'd8;
   localparam logic [IdxWidth-1:0] IdxMax      = 17'h1FFFF;

   // Parameter bytes run up to length + this offset
   localparam logic [IdxWidth-1:0] ParamEndOffset = 17'd2;

   localparam logic [7:0] SumGood = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  param_byte;
      logic        param_valid;
      logic        frame_done;
      logic [15:0] frame_length;
      logic [7:0]  frame_ident;
      logic [15:0] command_chars;
      logic [7:0]  command_status;
      logic        checksum_ok;
   } rsp_payload_type;

   // Handshake control shared by the input stage and the parser
   typedef struct packed {
      logic item_valid;
      logic advance;
   } stage_ctrl_type;

   // What the parser hands to the result register
   typedef struct packed {
      logic            has_result;
      rsp_payload_type payload;
   } parse_out_type;

endpackage

/* rtl/atdf_in_stage.sv */
// Input register of the AT response deframer: holds one accepted byte.
// Depends on atdf_pkg.
module atdf_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  atdf_pkg::req_payload_type req_payload,
   input  logic                     advance,
   output logic                     item_valid,
   output atdf_pkg::req_payload_type item_payload
);

   logic                      valid_ff;
   logic                      valid_in;
   atdf_pkg::req_payload_type payload_ff;
   logic                      accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload until the next transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         payload_ff <= req_payload;
      end
   end

   assign item_valid   = valid_ff;
   assign item_payload = payload_ff;

endmodule

/* rtl/atdf_parser.sv */
// Frame parser of the AT response deframer: byte index, captured header
// fields and running sum, plus the result of the byte at hand.
// Depends on atdf_pkg.
module atdf_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  atdf_pkg::stage_ctrl_type  ctrl,
   input  atdf_pkg::req_payload_type item,
   output atdf_pkg::parse_out_type   result
);

   logic                              in_frame_ff, in_frame_in;
   logic [atdf_pkg::IdxWidth-1:0]     byte_index_ff, byte_index_in;
   logic [15:0]                       length_ff, length_in;
   logic [7:0]                        ident_ff, ident_in;
   logic [15:0]                       command_ff, command_in;
   logic [7:0]                        status_ff, status_in;
   logic [7:0]                        sum_ff, sum_in;

   logic                              active;
   logic [atdf_pkg::IdxWidth-1:0]     idx;
   logic [atdf_pkg::IdxWidth-1:0]     param_end;
   logic                              pv;

   assign active = item.first_byte || in_frame_ff;
   assign idx    = item.first_byte ? '0 : byte_index_ff;

   always_comb begin
      // a first byte starts from cleared fields
      length_in  = item.first_byte ? 16'd0 : length_ff;
      ident_in   = item.first_byte ? 8'd0  : ident_ff;
      command_in = item.first_byte ? 16'd0 : command_ff;
      status_in  = item.first_byte ? 8'd0  : status_ff;
      sum_in     = item.first_byte ? 8'd0  : sum_ff;

      unique case (idx)
         atdf_pkg::IdxLenHi:  length_in[15:8]  = item.data_byte;
         atdf_pkg::IdxLenLo:  length_in[7:0]   = item.data_byte;
         atdf_pkg::IdxIdent:  ident_in         = item.data_byte;
         atdf_pkg::IdxCmdHi:  command_in[15:8] = item.data_byte;
         atdf_pkg::IdxCmdLo:  command_in[7:0]  = item.data_byte;
         atdf_pkg::IdxStatus: status_in        = item.data_byte;
         default: ;
      endcase

      if (idx >= atdf_pkg::IdxSumStart) begin
         sum_in = sum_in + item.data_byte;
      end

      byte_index_in = (idx == atdf_pkg::IdxMax) ? idx : idx + 1'b1;
      in_frame_in   = !item.last_byte;
   end

   assign param_end = {1'b0, length_in} + atdf_pkg::ParamEndOffset;
   assign pv        = (idx >= atdf_pkg::IdxParam) && (idx <= param_end);

   always_comb begin
      result                        = '0;
      result.has_result             = active && (pv || item.last_byte);
      if (pv) begin
         result.payload.param_byte  = item.data_byte;
         result.payload.param_valid = 1'b1;
      end
      if (item.last_byte) begin
         result.payload.frame_done     = 1'b1;
         result.payload.frame_length   = length_in;
         result.payload.frame_ident    = ident_in;
         result.payload.command_chars  = command_in;
         result.payload.command_status = status_in;
         result.payload.checksum_ok    = (sum_in == atdf_pkg::SumGood);
      end
   end

   // bytes outside a frame leave the state alone
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_index_ff <= '0;
         length_ff     <= '0;
         ident_ff      <= '0;
         command_ff    <= '0;
         status_ff     <= '0;
         sum_ff        <= '0;
      end else if (ctrl.item_valid && ctrl.advance && active) begin
         in_frame_ff   <= in_frame_in;
         byte_index_ff <= byte_index_in;
         length_ff     <= length_in;
         ident_ff      <= ident_in;
         command_ff    <= command_in;
         status_ff     <= status_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

/* rtl/atdf_out_stage.sv */
// Result register of the AT response deframer: holds one result until the
// downstream side takes it. Depends on atdf_pkg.
module atdf_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  atdf_pkg::rsp_payload_type load_payload,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output atdf_pkg::rsp_payload_type rsp_payload
);

   logic                      valid_ff;
   atdf_pkg::rsp_payload_type payload_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= load_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

/* rtl/at_response_deframer.sv */
// AT command response deframer, top level. Depends on atdf_pkg, atdf_in_stage,
// atdf_parser and atdf_out_stage.
// An accepted byte is held in the input register, and its result then in the
// result register that drives rsp_valid. Throughput: one byte per cycle while
// rsp_stall stays low; the result register sets the pace.
// Reset (synchronous, active high) empties both registers and closes any frame.
module at_response_deframer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  atdf_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output atdf_pkg::rsp_payload_type rsp_payload
);

   atdf_pkg::stage_ctrl_type  ctrl;
   atdf_pkg::req_payload_type item;
   atdf_pkg::parse_out_type   parsed;
   logic                      item_valid;
   logic                      out_free;
   logic                      load;

   // Advance the held byte whenever the result register can take a transfer;
   // a byte that yields no result still waits for that slot to stay in order.
   assign ctrl.item_valid = item_valid;
   assign ctrl.advance    = item_valid && out_free;

   // Load a result only for bytes that produce one
   assign load = ctrl.advance && parsed.has_result;

   atdf_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .advance      (ctrl.advance),
      .item_valid   (item_valid),
      .item_payload (item)
   );

   // Header capture, parameter pass-through and checksum
   atdf_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .result (parsed)
   );

   atdf_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .load_payload (parsed.payload),
      .free         (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

/* verif/atdf_checker.sv */
// Scoreboard for the AT response deframer: mirrors the frame parser, queues the
// results each accepted byte should cause and compares every rsp transfer.
// Depends on atdf_pkg.
module atdf_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  atdf_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  atdf_pkg::rsp_payload_type rsp_payload,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Mirror of the parser state
   logic                          frame_open;
   logic [atdf_pkg::IdxWidth-1:0] next_index;
   logic [15:0]                   length_field;
   logic [7:0]                    ident_field;
   logic [15:0]                   command_field;
   logic [7:0]                    status_field;
   logic [7:0]                    byte_sum;

   atdf_pkg::rsp_payload_type expected_results[$];
   atdf_pkg::rsp_payload_type want;
   atdf_pkg::rsp_payload_type predicted;
   logic                      produced;
   int                        errors = 0;

   task automatic clear_fields();
      next_index    = '0;
      length_field  = '0;
      ident_field   = '0;
      command_field = '0;
      status_field  = '0;
      byte_sum      = '0;
   endtask

   task automatic decode_byte(input atdf_pkg::req_payload_type item,
                              output logic has_result,
                              output atdf_pkg::rsp_payload_type res);
      logic [atdf_pkg::IdxWidth-1:0] idx;
      logic                          param_hit;
      has_result = 1'b0;
      res        = '0;
      if (item.first_byte) begin
         clear_fields();
         frame_open = 1'b1;
         idx        = '0;
      end else if (!frame_open) begin
         return;
      end else begin
         idx = next_index;
      end
      next_index = (idx == atdf_pkg::IdxMax) ? atdf_pkg::IdxMax : idx + 1'b1;
      case (idx)
         atdf_pkg::IdxLenHi:  length_field[15:8]  = item.data_byte;
         atdf_pkg::IdxLenLo:  length_field[7:0]   = item.data_byte;
         atdf_pkg::IdxIdent:  ident_field         = item.data_byte;
         atdf_pkg::IdxCmdHi:  command_field[15:8] = item.data_byte;
         atdf_pkg::IdxCmdLo:  command_field[7:0]  = item.data_byte;
         atdf_pkg::IdxStatus: status_field        = item.data_byte;
         default: ;
      endcase
      if (idx >= atdf_pkg::IdxSumStart) byte_sum = byte_sum + item.data_byte;
      param_hit = (idx >= atdf_pkg::IdxParam) &&
                  (idx <= {1'b0, length_field} + atdf_pkg::ParamEndOffset);
      if (param_hit) begin
         res.param_byte  = item.data_byte;
         res.param_valid = 1'b1;
      end
      if (item.last_byte) begin
         res.frame_done     = 1'b1;
         res.frame_length   = length_field;
         res.frame_ident    = ident_field;
         res.command_chars  = command_field;
         res.command_status = status_field;
         res.checksum_ok    = (byte_sum == atdf_pkg::SumGood);
         frame_open         = 1'b0;
      end
      has_result = param_hit || item.last_byte;
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_open = 1'b0;
         clear_fields();
         expected_results.delete();
      end else begin
         // Retire the result first; a byte accepted at this edge cannot show up yet
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_payload);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("param_byte", 16'(want.param_byte),
                           16'(rsp_payload.param_byte));
               check_field("param_valid", 16'(want.param_valid),
                           16'(rsp_payload.param_valid));
               check_field("frame_done", 16'(want.frame_done),
                           16'(rsp_payload.frame_done));
               check_field("frame_length", want.frame_length, rsp_payload.frame_length);
               check_field("frame_ident", 16'(want.frame_ident),
                           16'(rsp_payload.frame_ident));
               check_field("command_chars", want.command_chars, rsp_payload.command_chars);
               check_field("command_status", 16'(want.command_status),
                           16'(rsp_payload.command_status));
               check_field("checksum_ok", 16'(want.checksum_ok),
                           16'(rsp_payload.checksum_ok));
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_payload, produced, predicted);
            if (produced) expected_results.push_back(predicted);
         end
      end
      fail_count <= errors;
      pending    <= expected_results.size();
   end

endmodule

/* verif/tb_at_response_deframer.sv */
// Testbench top for the AT response deframer: drives framed byte streams with
// random idling on both sides and reports the verdict from the scoreboard.
// Depends on atdf_pkg, at_response_deframer and atdf_checker.
module tb_at_response_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   atdf_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   atdf_pkg::rsp_payload_type rsp_payload;

   int fail_count;
   int pending;

   // no_idle and hold_off_req are shared between the sender and the receiver
   bit no_idle       = 1'b0;
   bit hold_off_req  = 1'b0;
   bit hold_off_done = 1'b0;

   // Bytes of the frame being built, delimiter first
   logic [7:0] frame_bytes[$];

   always #10 clock = ~clock;

   at_response_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   atdf_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Offer one byte after a random gap and hold it until the transfer happens.
   // Valid stays high into the next byte when no gap is drawn.
   task automatic send_byte(input logic [7:0] value, input logic first, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, first_byte: first, last_byte: last};
      do @(posedge clock); while (req_stall);
   endtask

   // Send frame_bytes with first_byte on the delimiter; when closing, append a
   // checksum byte that makes the sum good or a random one.
   task automatic send_frame(input bit close, input bit good_sum);
      logic [7:0] sum;
      sum = '0;
      foreach (frame_bytes[i]) begin
         if (i >= atdf_pkg::IdxSumStart) sum = sum + frame_bytes[i];
         send_byte(frame_bytes[i], i == 0, 1'b0);
      end
      if (close)
         send_byte(good_sum ? atdf_pkg::SumGood - sum : 8'($urandom_range(0, 255)),
                   1'b0, 1'b1);
   endtask

   // Receiver: draw a stall length for every result, then drop stall until a
   // transfer happens. Once asked, hold off long enough to back up the block.
   initial begin : receiver
      int gap;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (hold_off_req && !hold_off_done) begin
            gap           = 300;
            hold_off_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid || reset);
      end
   end

   // Sender and verdict
   initial begin : stimulus
      int          frame_total;
      int          pick;
      int          body;
      int          cut;
      logic [15:0] len;
      bit          closed;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Stray bytes outside any frame: drop them, even when flagged last
      send_byte(8'h55, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      // One-byte frame, first and last together
      send_byte(8'hFF, 1'b1, 1'b1);
      // Complete frame with two parameter bytes and a good checksum
      frame_bytes = '{8'h7E, 8'h00, 8'h07, 8'h88, 8'h01, 8'h4E, 8'h44, 8'h00, 8'hAB, 8'hFF};
      send_frame(1'b1, 1'b1);
      // Frame cut off by a new delimiter, then a short frame closing at the ident
      frame_bytes = '{8'h7E, 8'hFF, 8'hFF, 8'h00};
      send_frame(1'b0, 1'b0);
      frame_bytes = '{8'h7E, 8'h00, 8'h02, 8'h88};
      send_frame(1'b1, 1'b1);

      // Random frames, mostly well formed; ask the receiver for one long hold-off
      hold_off_req = 1'b1;
      frame_total  = 0;
      while (frame_total < 950) begin
         no_idle = ($urandom_range(0, 5) == 0);
         pick    = $urandom_range(0, 99);
         len     = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
         closed  = 1'b1;
         if (pick < 5) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            frame_total++;
         end else begin
            frame_bytes = '{8'($urandom_range(0, 255)), len[15:8], len[7:0]};
            // Well formed: the checksum follows index length+2
            if (pick < 75) body = (len <= 40) ? len : $urandom_range(0, 20);
            else           body = $urandom_range(0, 14);
            repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
            if (pick >= 90) begin
               // Leave the frame open; the next delimiter discards it
               cut = $urandom_range(1, frame_bytes.size());
               while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
               send_frame(1'b0, 1'b0);
               closed = 1'b0;
               frame_total += frame_bytes.size();
            end else begin
               send_frame(1'b1, $urandom_range(0, 4) != 0);
               frame_total += frame_bytes.size() + 1;
            end
         end
         // Noise between frames is ignored by the block
         if (closed && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
               send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;
      no_idle   = 1'b0;

      // Let the scoreboard see the last transfer, drain, then allow for latency
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("tb_at_response_deframer passed");
      end else begin
         $display("tb_at_response_deframer failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(20ms);
      $display("tb_at_response_deframer failed");
      $finish;
   end

endmodule
